>>> src/modbus_response_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// Modbus response decoder assertion macros
// Shared checks, clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RESPONSE_DECODER_CORE_DEFINES_SVH
`define MODBUS_RESPONSE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication
`define MRD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg
// Constants, codes and control types of the Modbus response decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mrd_pkg;

    localparam int MAX_COILS_DEF = 64;

    localparam int BYTE_W     = 8;
    localparam int ID_W       = 16;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WORDS_W    = 4;
    localparam int COILCNT_W  = 7;
    localparam int BITOFF_W   = 5;
    localparam int GO_W       = 5;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 56;
    localparam int TUSER_OUT_W = 3;

    localparam logic [POS_W-1:0] POS_ID_HI   = 9'd0;
    localparam logic [POS_W-1:0] POS_ID_LO   = 9'd1;
    localparam logic [POS_W-1:0] POS_FUNC    = 9'd7;
    localparam logic [POS_W-1:0] POS_LEN     = 9'd8;
    localparam logic [POS_W-1:0] HDR_BYTES   = 9'd9;
    localparam logic [POS_W-1:0] POS_MAX     = 9'd511;

    localparam logic [BYTE_W-1:0] FC_READ_COILS   = 8'd1;
    localparam logic [BYTE_W-1:0] FC_READ_HOLDING = 8'd3;
    localparam int                FC_EXC_BIT      = 7;

    localparam logic [STATUS_W-1:0] STAT_VALUE     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EXCEPTION = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_SHORT     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ID_ERR    = 2'd3;

    localparam logic KIND_REGISTER = 1'b0;
    localparam logic KIND_COIL     = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORDS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COIL_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_OFFSET  = 2'd3;

    typedef struct packed {
        logic byte_take;
        logic coil_step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic slot_free;
        logic burst_req;
        logic burst_last;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> src/mrd_ctrl.sv
// ----------------------------------------------------------------------------
// mrd_ctrl
// Controller: takes frame bytes, or steps a coil burst after a coil frame.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_byte_valid,
    input  mrd_pkg::t_dp_stat   i_stat,
    output logic                o_byte_ready,
    output mrd_pkg::t_ctrl_cmd  o_cmd
);

    localparam logic ST_ACCEPT = 1'b0;
    localparam logic ST_COIL   = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_byte_ready    = (r_state == ST_ACCEPT) && i_stat.slot_free;
        o_cmd.byte_take = o_byte_ready && i_byte_valid;
        o_cmd.coil_step = (r_state == ST_COIL) && i_stat.slot_free;
        n_state         = r_state;
        case (r_state)
            ST_ACCEPT: begin
                if (o_cmd.byte_take && i_stat.burst_req) begin
                    n_state = ST_COIL;
                end
            end
            ST_COIL: begin
                if (o_cmd.coil_step && i_stat.burst_last) begin
                    n_state = ST_ACCEPT;
                end
            end
            default: n_state = ST_ACCEPT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> src/mrd_datapath.sv
// ----------------------------------------------------------------------------
// mrd_datapath
// Frame parsing registers, configuration, coil burst registers and output item.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_datapath #(
    parameter int MAX_COILS = mrd_pkg::MAX_COILS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire  [mrd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [mrd_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire  [mrd_pkg::BYTE_W-1:0]          i_byte,
    input  wire                                 i_frame_end,
    input  mrd_pkg::t_ctrl_cmd                  i_cmd,
    output mrd_pkg::t_dp_stat                   o_stat,
    input  wire                                 i_out_ready,
    output logic                                o_out_valid,
    output logic [mrd_pkg::STATUS_W-1:0]        o_status,
    output logic [mrd_pkg::ID_W-1:0]            o_item_id,
    output logic                                o_value_kind,
    output logic [mrd_pkg::VALUE_W-1:0]         o_item_value,
    output logic [mrd_pkg::BYTE_W-1:0]          o_exception_code,
    output logic                                o_last
);

    localparam int CNT_W = $clog2(MAX_COILS + 1);

    // configuration
    logic [mrd_pkg::ID_W-1:0]      r_expected_id;
    logic [mrd_pkg::WORDS_W-1:0]   r_words;
    logic [mrd_pkg::COILCNT_W-1:0] r_coil_count;
    logic [mrd_pkg::BITOFF_W-1:0]  r_bit_offset;

    // frame state
    logic [mrd_pkg::POS_W-1:0]     r_pos,      n_pos;
    logic [mrd_pkg::ID_W-1:0]      r_seen_id,  n_seen_id;
    logic [mrd_pkg::BYTE_W-1:0]    r_fc,       n_fc;
    logic [mrd_pkg::BYTE_W-1:0]    r_len,      n_len;
    logic                          r_rejected, n_rejected;
    logic [15:0]                   r_coil_word, n_coil_word;
    logic [mrd_pkg::VALUE_W-1:0]   r_assembly, n_assembly;
    logic [mrd_pkg::GO_W-1:0]      r_go,       n_go;
    logic [mrd_pkg::BYTE_W-1:0]    r_group,    n_group;

    // coil burst
    logic [mrd_pkg::ID_W-1:0]      r_burst_id;
    logic [15:0]                   r_coil_shift;
    logic [CNT_W-1:0]              r_coil_left;

    // output item
    logic                          r_out_valid;
    logic [mrd_pkg::STATUS_W-1:0]  r_status;
    logic [mrd_pkg::ID_W-1:0]      r_item_id;
    logic                          r_kind;
    logic [mrd_pkg::VALUE_W-1:0]   r_value;
    logic [mrd_pkg::BYTE_W-1:0]    r_exc;
    logic                          r_last;

    // per-byte result
    logic                          res_valid;
    logic [mrd_pkg::STATUS_W-1:0]  res_status;
    logic [mrd_pkg::ID_W-1:0]      res_id;
    logic [mrd_pkg::VALUE_W-1:0]   res_value;
    logic [mrd_pkg::BYTE_W-1:0]    res_exc;
    logic                          burst_req;

    logic [mrd_pkg::POS_W-1:0]     off;
    logic [mrd_pkg::GO_W-1:0]      byte_cnt;
    logic [mrd_pkg::GO_W-1:0]      used_last;
    logic [mrd_pkg::GO_W:0]        go_inc;
    logic [CNT_W-1:0]              coil_cap;
    logic [mrd_pkg::BITOFF_W-1:0]  first_sh;

    assign off       = r_pos - mrd_pkg::HDR_BYTES;
    assign byte_cnt  = {r_words, 1'b0};
    assign used_last = (r_words == 4'd1) ? 5'd1 : 5'd3;
    assign go_inc    = {1'b0, r_go} + 6'd1;
    assign coil_cap  = (r_coil_count > mrd_pkg::COILCNT_W'(MAX_COILS))
                     ? CNT_W'(MAX_COILS) : CNT_W'(r_coil_count);
    assign first_sh  = (r_bit_offset == 5'd0) ? 5'd0 : r_bit_offset - 5'd1;

    always_comb begin
        n_pos       = r_pos;
        n_seen_id   = r_seen_id;
        n_fc        = r_fc;
        n_len       = r_len;
        n_rejected  = r_rejected;
        n_coil_word = r_coil_word;
        n_assembly  = r_assembly;
        n_go        = r_go;
        n_group     = r_group;
        res_valid   = 1'b0;
        res_status  = mrd_pkg::STAT_VALUE;
        res_id      = r_seen_id;
        res_value   = '0;
        res_exc     = '0;

        if (!r_rejected) begin
            if (r_pos == mrd_pkg::POS_ID_HI) begin
                n_seen_id = {i_byte, 8'h00};
            end else if (r_pos == mrd_pkg::POS_ID_LO) begin
                n_seen_id = {r_seen_id[15:8], i_byte};
            end else if (r_pos == mrd_pkg::POS_FUNC) begin
                n_fc = i_byte;
            end else if (r_pos == mrd_pkg::POS_LEN) begin
                n_len = i_byte;
                if (r_fc[mrd_pkg::FC_EXC_BIT]) begin
                    res_valid  = 1'b1;
                    res_status = mrd_pkg::STAT_EXCEPTION;
                    res_exc    = i_byte;
                    n_rejected = 1'b1;
                end else if (r_seen_id != r_expected_id) begin
                    res_valid  = 1'b1;
                    res_status = mrd_pkg::STAT_ID_ERR;
                    n_rejected = 1'b1;
                end
            end else if (r_pos >= mrd_pkg::HDR_BYTES) begin
                if (off < {1'b0, r_len}) begin
                    if (r_fc == mrd_pkg::FC_READ_COILS) begin
                        if (off == 9'd0) begin
                            n_coil_word[7:0] = r_coil_word[7:0] | i_byte;
                        end else if (off == 9'd1) begin
                            n_coil_word[15:8] = r_coil_word[15:8] | i_byte;
                        end
                    end else if (r_fc == mrd_pkg::FC_READ_HOLDING && r_words != 4'd0) begin
                        case (r_go)
                            5'd0:    n_assembly = {16'h0000, i_byte, 8'h00};
                            5'd1:    n_assembly = r_assembly | {24'h000000, i_byte};
                            5'd2:    n_assembly = r_assembly | {i_byte, 24'h000000};
                            5'd3:    n_assembly = r_assembly | {8'h00, i_byte, 16'h0000};
                            default: n_assembly = r_assembly;
                        endcase
                        if (r_go == used_last) begin
                            res_valid = 1'b1;
                            res_id    = r_seen_id + {8'h00, r_group};
                            res_value = (r_words == 4'd1) ? {16'h0000, n_assembly[15:0]}
                                                          : n_assembly;
                        end
                        if (go_inc >= {1'b0, byte_cnt}) begin
                            n_go    = '0;
                            n_group = r_group + 8'd1;
                        end else begin
                            n_go = go_inc[mrd_pkg::GO_W-1:0];
                        end
                    end
                end
            end
        end

        if (r_pos != mrd_pkg::POS_MAX) begin
            n_pos = r_pos + 9'd1;
        end

        burst_req = i_frame_end && !n_rejected && (n_pos >= mrd_pkg::HDR_BYTES)
                  && (n_fc == mrd_pkg::FC_READ_COILS) && (coil_cap != '0);

        if (i_frame_end) begin
            if (n_pos < mrd_pkg::HDR_BYTES) begin
                res_valid  = 1'b1;
                res_status = mrd_pkg::STAT_SHORT;
                res_id     = n_seen_id;
                res_value  = '0;
                res_exc    = '0;
            end
        end
    end

    assign o_stat.burst_req  = burst_req;
    assign o_stat.slot_free  = !r_out_valid || i_out_ready;
    assign o_stat.burst_last = (r_coil_left == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= '0;
            r_words       <= 4'd2;
            r_coil_count  <= '0;
            r_bit_offset  <= 5'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mrd_pkg::CFG_EXPECTED_ID: r_expected_id <= i_cfg_wdata;
                mrd_pkg::CFG_WORDS:       r_words <= i_cfg_wdata[mrd_pkg::WORDS_W-1:0];
                mrd_pkg::CFG_COIL_COUNT:  r_coil_count <= i_cfg_wdata[mrd_pkg::COILCNT_W-1:0];
                mrd_pkg::CFG_BIT_OFFSET:  r_bit_offset <= i_cfg_wdata[mrd_pkg::BITOFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_seen_id   <= '0;
            r_fc        <= '0;
            r_len       <= '0;
            r_rejected  <= 1'b0;
            r_coil_word <= '0;
            r_assembly  <= '0;
            r_go        <= '0;
            r_group     <= '0;
        end else if (i_cmd.byte_take) begin
            if (i_frame_end) begin
                r_pos       <= '0;
                r_seen_id   <= '0;
                r_fc        <= '0;
                r_len       <= '0;
                r_rejected  <= 1'b0;
                r_coil_word <= '0;
                r_assembly  <= '0;
                r_go        <= '0;
                r_group     <= '0;
            end else begin
                r_pos       <= n_pos;
                r_seen_id   <= n_seen_id;
                r_fc        <= n_fc;
                r_len       <= n_len;
                r_rejected  <= n_rejected;
                r_coil_word <= n_coil_word;
                r_assembly  <= n_assembly;
                r_go        <= n_go;
                r_group     <= n_group;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coil_left <= '0;
        end else if (i_cmd.byte_take && burst_req) begin
            r_coil_left <= coil_cap;
        end else if (i_cmd.coil_step) begin
            r_coil_left <= r_coil_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_take && burst_req) begin
            r_burst_id   <= n_seen_id;
            r_coil_shift <= n_coil_word >> first_sh;
        end else if (i_cmd.coil_step) begin
            r_burst_id   <= r_burst_id + 16'd1;
            r_coil_shift <= {1'b0, r_coil_shift[15:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.byte_take && res_valid) || i_cmd.coil_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.coil_step) begin
            r_status  <= mrd_pkg::STAT_VALUE;
            r_item_id <= r_burst_id;
            r_kind    <= mrd_pkg::KIND_COIL;
            r_value   <= {31'd0, r_coil_shift[0]};
            r_exc     <= '0;
            r_last    <= o_stat.burst_last;
        end else if (i_cmd.byte_take && res_valid) begin
            r_status  <= res_status;
            r_item_id <= res_id;
            r_kind    <= mrd_pkg::KIND_REGISTER;
            r_value   <= res_value;
            r_exc     <= res_exc;
            r_last    <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_item_id        = r_item_id;
    assign o_value_kind     = r_kind;
    assign o_item_value     = r_value;
    assign o_exception_code = r_exc;
    assign o_last           = r_last;

endmodule

`default_nettype wire

>>> src/modbus_response_decoder_core.sv
// ----------------------------------------------------------------------------
// modbus_response_decoder_core
// Modbus TCP response decoder: checks header, emits register values and coils.
//
//   channel    direction  tdata (low bit up)                      tuser / tlast
//   s_axis     in         data_byte[7:0]                          tlast=frame_end
//   m_axis     out        item_id, item_value, exception_code     status, value_kind
//                                                                 tlast=last
//   i_cfg_*    in         register index 0..3, 16-bit write data  -
//
// One input item is taken per cycle while the output register is free.
// The final byte of a function 1 frame that passes the header checks starts a coil burst
// of coil_count items (capped at MAX_COILS; none if zero), one coil item per cycle from
// the controller while the output register is free; s_axis_tready stays low meanwhile.
// Output items wait in a single output register; a stall on m_axis holds input.
// Reset is synchronous, active low, and leaves the block ready the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_response_decoder_core_defines.svh"

module modbus_response_decoder_core #(
    parameter int MAX_COILS = mrd_pkg::MAX_COILS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire  [mrd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [mrd_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [mrd_pkg::TDATA_IN_W-1:0]      s_axis_tdata,  // data_byte
    input  wire                                 s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [mrd_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,  // item_id, item_value, exception_code
    output logic [mrd_pkg::TUSER_OUT_W-1:0]     m_axis_tuser,  // status, value_kind
    output logic                                m_axis_tlast
);

    mrd_pkg::t_ctrl_cmd               cmd;
    mrd_pkg::t_dp_stat                stat;
    logic [mrd_pkg::STATUS_W-1:0]     out_status;
    logic [mrd_pkg::ID_W-1:0]         out_item_id;
    logic                             out_kind;
    logic [mrd_pkg::VALUE_W-1:0]      out_value;
    logic [mrd_pkg::BYTE_W-1:0]       out_exc;
    logic                             burst_start;
    logic                             burst_done;

    mrd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (s_axis_tvalid),
        .i_stat       (stat),
        .o_byte_ready (s_axis_tready),
        .o_cmd        (cmd)
    );

    mrd_datapath #(
        .MAX_COILS (MAX_COILS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_byte           (s_axis_tdata),
        .i_frame_end      (s_axis_tlast),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_status         (out_status),
        .o_item_id        (out_item_id),
        .o_value_kind     (out_kind),
        .o_item_value     (out_value),
        .o_exception_code (out_exc),
        .o_last           (m_axis_tlast)
    );

    assign m_axis_tdata = {out_exc, out_value, out_item_id};
    assign m_axis_tuser = {out_kind, out_status};

    assign burst_start = cmd.byte_take && stat.burst_req;
    assign burst_done  = cmd.coil_step && stat.burst_last;

    `MRD_ASSERT_SAME(a_no_byte_in_burst, cmd.coil_step, !s_axis_tready, "ready in coil burst")
    `MRD_ASSERT_NEXT(a_burst_blocks_input, burst_start, !s_axis_tready, "input open in burst")
    `MRD_ASSERT_NEXT(a_burst_last, burst_done, m_axis_tvalid && m_axis_tlast, "final coil not last")

endmodule

`default_nettype wire
